### src/pat2d_pkg.sv
`timescale 1ns / 1ps

package pat2d_pkg;

  localparam int COORD_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int ANGLE_BITS     = 10;
  localparam int MODE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  // pi * 2^62, and pi/180 at the same scale
  localparam logic [63:0] PI_Q62     = 64'hC90FDAA22168C235;
  localparam logic [63:0] PI_DEG_Q62 = PI_Q62 / 64'd180;
  localparam int          SERIES_TERMS = 13;
  // (2n)*(2n+1) for n = 1..SERIES_TERMS
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TRANSLATE = 3'd0,
    MODE_ROTATE    = 3'd1,
    MODE_SCALE     = 3'd2,
    MODE_SHEAR     = 3'd3,
    MODE_REFLECT   = 3'd4
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE         = 3'd0,
    REG_PARAM_X      = 3'd1,
    REG_PARAM_Y      = 3'd2,
    REG_ANGLE_DEG    = 3'd3,
    REG_REFLECT_AXIS = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]         mode;
    logic signed [COORD_BITS-1:0] param_x;
    logic signed [COORD_BITS-1:0] param_y;
    logic signed [ANGLE_BITS-1:0] angle_deg;
    logic                         reflect_axis;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         saturated;
  } result_t;

  // Sine of k degrees (k = 0..90) by Taylor series at 62 fraction bits,
  // rounded to frac fraction bits. Evaluated at elaboration only.
  function automatic logic [63:0] sin_first_quadrant(input int k, input int frac);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] p;
    x = PI_DEG_Q62 * 64'(k);
    p = {64'd0, x} * {64'd0, x};
    x2 = p[125:62];
    term = x;
    sum = x;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      p = {64'd0, term} * {64'd0, x2};
      term = p[125:62] / SERIES_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + (64'd1 << (61 - frac))) >> (62 - frac);
  endfunction

endpackage

### src/pat2d_cfg.sv
`timescale 1ns / 1ps

module pat2d_cfg (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [pat2d_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [pat2d_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output pat2d_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pat2d_pkg::REG_MODE:
          cfg.mode <= cfg_data[pat2d_pkg::MODE_BITS-1:0];
        pat2d_pkg::REG_PARAM_X:
          cfg.param_x <= cfg_data[pat2d_pkg::COORD_BITS-1:0];
        pat2d_pkg::REG_PARAM_Y:
          cfg.param_y <= cfg_data[pat2d_pkg::COORD_BITS-1:0];
        pat2d_pkg::REG_ANGLE_DEG:
          cfg.angle_deg <= cfg_data[pat2d_pkg::ANGLE_BITS-1:0];
        pat2d_pkg::REG_REFLECT_AXIS:
          cfg.reflect_axis <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### src/pat2d_trig.sv
`timescale 1ns / 1ps

module pat2d_trig #(
  parameter int TRIG_FRAC_BITS = pat2d_pkg::TRIG_FRAC_BITS
) (
  input  logic signed [pat2d_pkg::ANGLE_BITS-1:0] angle_deg,
  output logic signed [TRIG_FRAC_BITS+1:0]        sin_v,
  output logic signed [TRIG_FRAC_BITS+1:0]        cos_v
);

  localparam int TW = TRIG_FRAC_BITS + 2;

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } quad_t;

  // quarter-wave table, 0..90 degrees, magnitude 0..2^TRIG_FRAC_BITS
  logic [TRIG_FRAC_BITS:0] tab [91];

  for (genvar k = 0; k <= 90; k++) begin : g_tab
    localparam logic [63:0] VAL = pat2d_pkg::sin_first_quadrant(k, TRIG_FRAC_BITS);
    assign tab[k] = VAL[TRIG_FRAC_BITS:0];
  end

  function automatic quad_t fold(input logic [8:0] d);
    quad_t q;
    if (d <= 9'd90) begin
      q.neg = 1'b0;
      q.idx = 7'(d);
    end else if (d <= 9'd180) begin
      q.neg = 1'b0;
      q.idx = 7'(9'd180 - d);
    end else if (d <= 9'd270) begin
      q.neg = 1'b1;
      q.idx = 7'(d - 9'd180);
    end else begin
      q.neg = 1'b1;
      q.idx = 7'(9'd360 - d);
    end
    return q;
  endfunction

  logic signed [10:0] a;
  logic [8:0]         d_sin;
  logic [8:0]         d_cos;
  quad_t              qs;
  quad_t              qc;
  logic signed [TW-1:0] mag_s;
  logic signed [TW-1:0] mag_c;

  assign a = 11'(angle_deg);

  // reduce to 0..359
  always_comb begin
    if (a >= 11'sd360) begin
      d_sin = 9'(a - 11'sd360);
    end else if (a >= 11'sd0) begin
      d_sin = 9'(a);
    end else if (a >= -11'sd360) begin
      d_sin = 9'(a + 11'sd360);
    end else begin
      d_sin = 9'(a + 11'sd720);
    end
  end

  assign d_cos = (d_sin >= 9'd270) ? (d_sin - 9'd270) : (d_sin + 9'd90);

  assign qs = fold(d_sin);
  assign qc = fold(d_cos);

  assign mag_s = {1'b0, tab[qs.idx]};
  assign mag_c = {1'b0, tab[qc.idx]};

  assign sin_v = qs.neg ? -mag_s : mag_s;
  assign cos_v = qc.neg ? -mag_c : mag_c;

endmodule

### src/pat2d_pipe.sv
`timescale 1ns / 1ps

module pat2d_pipe #(
  parameter int TRIG_FRAC_BITS = pat2d_pkg::TRIG_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pat2d_pkg::cfg_t                  cfg,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_v,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_v,
  input  logic                             pt_valid,
  output logic                             pt_stall,
  input  pat2d_pkg::point_t                pt,
  output logic                             res_valid,
  input  logic                             res_stall,
  output pat2d_pkg::result_t               res
);

  localparam int CW = pat2d_pkg::COORD_BITS;
  localparam int F  = TRIG_FRAC_BITS;
  localparam int TW = F + 2;
  localparam int BW = (CW > TW) ? CW : TW;
  localparam int PW = CW + BW;
  localparam int SW = PW + 1;

  localparam logic signed [SW-1:0] HI   = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] LO   = ~HI;
  localparam logic signed [SW-1:0] BIAS = {{(SW-F){1'b0}}, {F{1'b1}}};

  // stage A: captured point and trig values
  logic                 a_valid;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [TW-1:0] a_s;
  logic signed [TW-1:0] a_c;

  // stage B: products
  logic                 b_valid;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [PW-1:0] b_m0;
  logic signed [PW-1:0] b_m1;
  logic signed [PW-1:0] b_m2;
  logic signed [PW-1:0] b_m3;

  // stage C: unclamped sums
  logic                 c_valid;
  logic                 c_rot;
  logic signed [SW-1:0] c_rx;
  logic signed [SW-1:0] c_ry;

  logic a_ready;
  logic b_ready;
  logic c_ready;
  logic d_ready;

  assign d_ready  = !res_valid || !res_stall;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign pt_stall = !a_ready;

  // stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_x <= pt.in_x;
      a_y <= pt.in_y;
      a_s <= sin_v;
      a_c <= cos_v;
    end
  end

  // stage B: two shared multipliers, two for rotate only
  logic is_rot;
  logic is_shear;
  logic is_scale;
  logic signed [CW-1:0] mul_a0;
  logic signed [CW-1:0] mul_a2;
  logic signed [BW-1:0] mul_b0;
  logic signed [BW-1:0] mul_b2;
  logic signed [BW-1:0] s_ext;
  logic signed [BW-1:0] c_ext;

  assign is_rot   = (cfg.mode == pat2d_pkg::MODE_ROTATE);
  assign is_shear = (cfg.mode == pat2d_pkg::MODE_SHEAR);
  assign is_scale = (cfg.mode == pat2d_pkg::MODE_SCALE);
  assign s_ext    = BW'(a_s);
  assign c_ext    = BW'(a_c);
  assign mul_a0   = is_shear ? a_y : a_x;
  assign mul_b0   = is_rot ? c_ext : BW'(cfg.param_x);
  assign mul_a2   = is_scale ? a_y : a_x;
  assign mul_b2   = is_rot ? s_ext : BW'(cfg.param_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_x  <= a_x;
      b_y  <= a_y;
      b_m0 <= PW'(mul_a0) * PW'(mul_b0);
      b_m1 <= PW'(a_y) * PW'(s_ext);
      b_m2 <= PW'(mul_a2) * PW'(mul_b2);
      b_m3 <= PW'(a_y) * PW'(c_ext);
    end
  end

  // stage C
  logic signed [SW-1:0] rx_next;
  logic signed [SW-1:0] ry_next;

  always_comb begin
    rx_next = SW'(b_x);
    ry_next = SW'(b_y);
    case (cfg.mode)
      pat2d_pkg::MODE_TRANSLATE: begin
        rx_next = SW'(b_x) + SW'(cfg.param_x);
        ry_next = SW'(b_y) + SW'(cfg.param_y);
      end
      pat2d_pkg::MODE_ROTATE: begin
        rx_next = SW'(b_m0) - SW'(b_m1);
        ry_next = SW'(b_m2) + SW'(b_m3);
      end
      pat2d_pkg::MODE_SCALE: begin
        rx_next = SW'(b_m0);
        ry_next = SW'(b_m2);
      end
      pat2d_pkg::MODE_SHEAR: begin
        rx_next = SW'(b_x) + SW'(b_m0);
        ry_next = SW'(b_m2) + SW'(b_y);
      end
      pat2d_pkg::MODE_REFLECT: begin
        if (cfg.reflect_axis) begin
          rx_next = -SW'(b_x);
        end else begin
          ry_next = -SW'(b_y);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_rot <= is_rot;
      c_rx  <= rx_next;
      c_ry  <= ry_next;
    end
  end

  // stage D: drop rotate fraction toward zero, then clamp
  logic signed [SW-1:0] tx;
  logic signed [SW-1:0] ty;
  logic                 sat_x;
  logic                 sat_y;
  pat2d_pkg::result_t   res_next;

  always_comb begin
    tx = c_rx;
    ty = c_ry;
    if (c_rot) begin
      tx = c_rx[SW-1] ? ((c_rx + BIAS) >>> F) : (c_rx >>> F);
      ty = c_ry[SW-1] ? ((c_ry + BIAS) >>> F) : (c_ry >>> F);
    end
    sat_x = (tx > HI) || (tx < LO);
    sat_y = (ty > HI) || (ty < LO);
    res_next.out_x = sat_x ? (tx[SW-1] ? LO[CW-1:0] : HI[CW-1:0]) : tx[CW-1:0];
    res_next.out_y = sat_y ? (ty[SW-1] ? LO[CW-1:0] : HI[CW-1:0]) : ty[CW-1:0];
    res_next.saturated = sat_x || sat_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (d_ready) begin
      res_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      res <= res_next;
    end
  end

endmodule

### src/point_affine_transform_2d.sv
`timescale 1ns / 1ps

// 2D point transform: translate, rotate, scale, shear or reflect one signed
// point per request, with the mode and its parameters held in configuration
// registers. The datapath is a four-stage pipeline (capture with sine/cosine
// lookup, multiply, sum, truncate and clamp): a new point is taken every cycle
// while pt_stall is low, and each passes the capture, product, sum and output
// registers in turn, held back by res_stall. Rotation uses a 91-entry
// quarter-wave sine table with TRIG_FRAC_BITS fraction bits and truncates
// toward zero; every result saturates to the coordinate range and flags it.
module point_affine_transform_2d #(
  parameter int TRIG_FRAC_BITS = pat2d_pkg::TRIG_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pat2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pat2d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                 pt_valid,
  output logic                                 pt_stall,
  input  pat2d_pkg::point_t                    pt,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output pat2d_pkg::result_t                   res
);

  pat2d_pkg::cfg_t                  cfg;
  logic signed [TRIG_FRAC_BITS+1:0] sin_v;
  logic signed [TRIG_FRAC_BITS+1:0] cos_v;

  pat2d_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pat2d_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .angle_deg (cfg.angle_deg),
    .sin_v     (sin_v),
    .cos_v     (cos_v)
  );

  pat2d_pipe #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sin_v     (sin_v),
    .cos_v     (cos_v),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

### verif/point_affine_transform_2d_test.sv
`timescale 1ns / 1ps

module point_affine_transform_2d_test;
  import pat2d_pkg::*;

  // pi * 2^62
  localparam logic [63:0] PI_FIXED62 = 64'hC90FDAA22168C235;
  localparam int SINE_TERMS = 13;
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MODE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic pt_valid = 1'b0;
  logic pt_stall;
  point_t pt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  result_t res;

  longint sine_q[0:90];
  cfg_t active_cfg = '0;
  result_t expected_q[$];
  int taken_count = 0;
  int fail_count = 0;
  int res_hold = 0;
  bit pace_on = 1'b1;

  point_affine_transform_2d DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pt_valid(pt_valid),
    .pt_stall(pt_stall),
    .pt(pt),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Q62 product: bits 125:62 of the full 128-bit product
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  function automatic longint series_sine(int k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] acc;
    ang = (PI_FIXED62 / 64'd180) * 64'(k);
    ang_sq = q62_mul(ang, ang);
    term = ang;
    acc = ang;
    for (int n = 1; n <= SINE_TERMS; n++) begin
      term = q62_mul(term, ang_sq) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    // round to nearest, ties up
    return longint'((acc + (64'd1 << (61 - TRIG_FRAC_BITS))) >> (62 - TRIG_FRAC_BITS));
  endfunction

  function automatic longint sine_deg(int d);
    if (d <= 90) return sine_q[d];
    if (d <= 180) return sine_q[180 - d];
    if (d <= 270) return -sine_q[d - 180];
    return -sine_q[360 - d];
  endfunction

  // divide by 2^frac, truncating toward zero
  function automatic longint drop_frac(longint v);
    if (v < 0) return -((-v) >> TRIG_FRAC_BITS);
    return v >> TRIG_FRAC_BITS;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic result_t transform_point(cfg_t c, point_t p);
    longint x, y, px, py, rx, ry, sn, cs, a;
    longint cx, cy;
    int d;
    result_t r;
    x = $signed(p.in_x);
    y = $signed(p.in_y);
    px = $signed(c.param_x);
    py = $signed(c.param_y);
    rx = x;
    ry = y;
    case (c.mode)
      MODE_TRANSLATE: begin
        rx = x + px;
        ry = y + py;
      end
      MODE_ROTATE: begin
        a = longint'($signed(c.angle_deg)) % 360;
        d = int'((a + 360) % 360);
        sn = sine_deg(d);
        cs = sine_deg((d + 90) % 360);
        rx = drop_frac(cs * x - sn * y);
        ry = drop_frac(sn * x + cs * y);
      end
      MODE_SCALE: begin
        rx = px * x;
        ry = py * y;
      end
      MODE_SHEAR: begin
        rx = x + px * y;
        ry = py * x + y;
      end
      MODE_REFLECT: begin
        if (c.reflect_axis == 1'b0) begin
          ry = -y;
        end else begin
          rx = -x;
        end
      end
      default: begin
        // unused codes pass the point through
      end
    endcase
    cx = clamp_coord(rx);
    cy = clamp_coord(ry);
    r.out_x = cx[COORD_BITS-1:0];
    r.out_y = cy[COORD_BITS-1:0];
    r.saturated = (cx != rx) || (cy != ry);
    return r;
  endfunction

  function automatic point_t mk_point(int x, int y);
    point_t p;
    p.in_x = COORD_BITS'(x);
    p.in_y = COORD_BITS'(y);
    return p;
  endfunction

  function automatic cfg_t make_cfg(int mode, int px, int py, int ang, int axis);
    cfg_t c;
    c.mode = MODE_BITS'(mode);
    c.param_x = COORD_BITS'(px);
    c.param_y = COORD_BITS'(py);
    c.angle_deg = ANGLE_BITS'(ang);
    c.reflect_axis = 1'(axis);
    return c;
  endfunction

  // corners, tiny values, moderate values or anything
  function automatic int random_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 2))
                                     : -32768 + int'($urandom_range(0, 2));
      1: return int'($urandom_range(0, 2)) - 1;
      2: return int'($urandom_range(0, 600)) - 300;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // record every accepted request
  always @(posedge clk) begin
    if (!rst && pt_valid && !pt_stall) begin
      expected_q.push_back(transform_point(active_cfg, pt));
      taken_count++;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $time,
                   $signed(res.out_x), $signed(res.out_y), res.saturated);
      end else begin
        want = expected_q.pop_front();
        if (res.out_x !== want.out_x || res.out_y !== want.out_y ||
            res.saturated !== want.saturated) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch expected x=%0d y=%0d sat=%0b got x=%0d y=%0d sat=%0b",
                     $time, $signed(want.out_x), $signed(want.out_y), want.saturated,
                     $signed(res.out_x), $signed(res.out_y), res.saturated);
        end
      end
      res_hold = pace_on ? $urandom_range(0, 19) : 0;
    end
  end

  always @(negedge clk) begin
    if (res_hold > 0) begin
      res_stall <= 1'b1;
      res_hold--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_point(point_t p);
    int gap;
    int target;
    gap = pace_on ? $urandom_range(0, 19) : 0;
    target = taken_count + 1;
    if (gap > 0) begin
      pt_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt <= p;
    pt_valid <= 1'b1;
    do @(negedge clk); while (taken_count < target);
  endtask

  task automatic drain_results();
    pt_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    active_cfg = c;
    write_reg(REG_MODE, CFG_DATA_BITS'(c.mode));
    write_reg(REG_PARAM_X, CFG_DATA_BITS'($signed(c.param_x)));
    write_reg(REG_PARAM_Y, CFG_DATA_BITS'($signed(c.param_y)));
    write_reg(REG_ANGLE_DEG, CFG_DATA_BITS'($signed(c.angle_deg)));
    write_reg(REG_REFLECT_AXIS, CFG_DATA_BITS'(c.reflect_axis));
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_point(mk_point(32767, -32768));
    send_point(mk_point(0, 0));
    drain_results();
  endtask

  task automatic test_translate();
    program_regs(make_cfg(MODE_TRANSLATE, 32767, -32768, 0, 0));
    send_point(mk_point(1, -1));
    send_point(mk_point(-32768, 32767));
    drain_results();
  endtask

  task automatic rotate_once(int ang, int x, int y);
    program_regs(make_cfg(MODE_ROTATE, 0, 0, ang, 0));
    send_point(mk_point(x, y));
    drain_results();
  endtask

  task automatic test_rotate();
    rotate_once(0, 32767, -32768);
    rotate_once(45, 32767, 32767);
    rotate_once(90, -32768, -32768);
    rotate_once(180, -32768, 12345);
    rotate_once(270, 12345, -6789);
    rotate_once(-90, 32767, -32768);
    rotate_once(-360, -1, 1);
    rotate_once(511, 20000, -20000);
    rotate_once(-512, -30000, 25000);
    rotate_once(359, 32767, 1);
  endtask

  task automatic test_scale();
    program_regs(make_cfg(MODE_SCALE, -1, 2, 0, 0));
    send_point(mk_point(-32768, 20000));
    send_point(mk_point(100, -100));
    drain_results();
  endtask

  task automatic test_shear();
    program_regs(make_cfg(MODE_SHEAR, 3, -2, 0, 0));
    send_point(mk_point(1000, -2000));
    send_point(mk_point(32767, 32767));
    drain_results();
  endtask

  task automatic test_reflect();
    // negating the most negative value clamps
    program_regs(make_cfg(MODE_REFLECT, 5, 5, 30, 0));
    send_point(mk_point(5, -32768));
    drain_results();
    program_regs(make_cfg(MODE_REFLECT, 5, 5, 30, 1));
    send_point(mk_point(-32768, 7));
    drain_results();
  endtask

  task automatic test_unused_modes();
    for (int m = int'(MODE_REFLECT) + 1; m < (1 << MODE_BITS); m++) begin
      program_regs(make_cfg(m, 32767, -32768, 90, 1));
      send_point(mk_point(-32768, 32767));
      drain_results();
    end
  endtask

  task automatic test_random_stream();
    int ang;
    for (int phase = 0; phase < 30; phase++) begin
      ang = ($urandom_range(0, 3) == 0) ? 90 * (int'($urandom_range(0, 8)) - 4)
                                        : int'($urandom_range(0, 1023));
      pace_on = ($urandom_range(0, 3) != 0);
      program_regs(make_cfg($urandom_range(0, 7), random_coord(), random_coord(), ang,
                            $urandom_range(0, 1)));
      for (int i = 0; i < 64; i++) begin
        send_point(mk_point(random_coord(), random_coord()));
        // hold off now and then until the pipeline is empty
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      drain_results();
    end
    pace_on = 1'b1;
  endtask

  initial begin
    for (int k = 0; k <= 90; k++) sine_q[k] = series_sine(k);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_translate();
    test_rotate();
    test_scale();
    test_shear();
    test_reflect();
    test_unused_modes();
    test_random_stream();
    drain_results();
    if (expected_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
